/* design/annexb_nal_unit_scanner_defines.svh */
// assertion macros shared by the start code scanner modules
// no dependencies; included inside module bodies
`ifndef ANNEXB_NAL_UNIT_SCANNER_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SCANNER_DEFINES_SVH

// checked on every rising edge, masked while reset is asserted
`define ANNEXB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ANNEXB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/annexb_pkg.sv */
// shared types and constants for the annex b start code scanner
// no dependencies
package annexb_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_UNIT   = 2'd2
  } scan_phase_e;

  typedef enum logic {
    REG_CODEC_MODE = 1'b0,
    REG_KEY_TYPE   = 1'b1
  } reg_index_e;

  localparam int unsigned OffsetBits = 24;
  localparam int unsigned LengthBits = 25;
  localparam int unsigned TypeBits   = 6;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrBits = 2;

  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h7E;
  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam int unsigned H264MinLen = 5;
  localparam int unsigned HevcMinLen = 7;

  localparam logic [23:0] RECENT_RESET = 24'hFFFFFF;

  typedef struct packed {
    logic                  kind;
    logic [OffsetBits-1:0] offset;
    logic [LengthBits-1:0] length;
    logic [TypeBits-1:0]   unit_type;
    logic                  type_valid;
    logic                  is_key;
    logic                  keyframe_found;
    logic                  last;
  } result_t;

  // one accepted byte makes at most a unit report and then a summary
  typedef struct packed {
    logic    rep;
    logic    sum;
    result_t rep_res;
    result_t sum_res;
  } push_t;

endpackage

/* design/annexb_nal_unit_scanner.sv */
// annex b nal unit scanner: input byte stream, unit reports out, apb registers
// uses annexb_pkg, annexb_scan_core and annexb_result_fifo
//
// s_axis carries one stream byte per beat in tdata, with tlast on the final
// byte of a buffer. m_axis carries one result per beat: tuser is the kind
// (unit report or buffer summary), tlast marks the summary that closes a buffer.
// A unit report comes when a unit ends at a 000000/000001 marker or at the
// buffer end; every buffer ends with a summary telling whether a keyframe was seen.
// A byte is taken in a cycle where s_axis_tready is high, and its results are
// registered into the result queue. Throughput is one byte per cycle while the
// queue has room; only a last byte that also closes a unit yields two results.
// Results wait in a four entry queue; s_axis_tready drops when fewer than two
// entries are free, so a stalled receiver backs up into the byte stream. Reset
// clears the scan state and queue and loads codec_mode 0 (h.264) and key_type 5.
// The user must write registers over apb only while the block is idle (unchecked).
module annexb_nal_unit_scanner #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [23:0] unit_offset, [48:24] unit_length,
                                      // [54:49] unit_type, [55] type_valid,
                                      // [56] is_key, [57] keyframe_found, rest 0
  output logic [0:0]  m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,   // last_result
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import annexb_pkg::*;

  logic                codec_mode_q, codec_mode_d;
  logic [TypeBits-1:0] key_type_q, key_type_d;
  logic                cfg_wr, in_fire, room, out_valid;
  reg_index_e          reg_sel;
  push_t               push;
  result_t             res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_e'(paddr[2]);

  always_comb begin
    codec_mode_d = codec_mode_q;
    key_type_d   = key_type_q;
    prdata       = '0;
    unique case (reg_sel)
      REG_CODEC_MODE: begin
        prdata = {31'd0, codec_mode_q};
        if (cfg_wr) codec_mode_d = pwdata[0];
      end
      REG_KEY_TYPE: begin
        prdata = {26'd0, key_type_q};
        if (cfg_wr) key_type_d = pwdata[TypeBits-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= 1'b0;
      key_type_q   <= TypeBits'(5);
    end else begin
      codec_mode_q <= codec_mode_d;
      key_type_q   <= key_type_d;
    end
  end

  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;

  annexb_scan_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .codec_mode_i (codec_mode_q),
    .key_type_i   (key_type_q),
    .push_o       (push)
  );

  annexb_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;
  assign m_axis_tdata  = {6'd0, res.keyframe_found, res.is_key, res.type_valid,
                          res.unit_type, res.length, res.offset};

endmodule

/* design/annexb_scan_core.sv */
// byte scanner state and result formation for the annex b scanner
// depends on annexb_pkg and annexb_nal_unit_scanner_defines.svh
module annexb_scan_core #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [7:0]                     byte_i,
  input  logic                           last_i,
  input  logic                           codec_mode_i,
  input  logic [annexb_pkg::TypeBits-1:0] key_type_i,
  output annexb_pkg::push_t              push_o
);
  import annexb_pkg::*;

  localparam int unsigned PW = POSITION_BITS;

  scan_phase_e           phase_q, phase_d, phase_a;
  logic [PW-1:0]         pos_q, pos_d;
  logic [23:0]           recent_q, recent_d;
  logic [PW-1:0]         start_q, start_d;
  logic [TypeBits-1:0]   type_q, type_d, type_a, hdr_type;
  logic                  key_seen_q, key_seen_d;

  logic                  two_zeros, hdr, term, open_unit, end_rep, rep;
  logic [PW:0]           term_len, end_len, rep_len, min_len;
  logic                  len_ok, key_hit, found;

  assign two_zeros = (recent_q[15:0] == 16'h0000);
  assign hdr_type  = codec_mode_i ? TypeBits'((byte_i & HEVC_TYPE_MASK) >> 1)
                                  : TypeBits'(byte_i & H264_TYPE_MASK);
  assign hdr  = (phase_q == PH_HEADER);
  assign term = (phase_q == PH_UNIT) && two_zeros && (byte_i <= START_CODE_END);
  assign type_a  = hdr ? hdr_type : type_q;
  assign phase_a = hdr ? PH_UNIT : (term ? PH_SEARCH : phase_q);
  assign open_unit = (phase_a == PH_SEARCH) && two_zeros && (byte_i == START_CODE_END)
                     && !last_i;
  assign end_rep = last_i && (phase_a == PH_UNIT);
  assign rep     = fire_i && (term || end_rep);

  // terminator length excludes the two zeros already counted in pos_q
  assign term_len = {1'b0, pos_q - PW'(2) - start_q};
  assign end_len  = {1'b0, pos_q - start_q} + (PW+1)'(1);
  assign rep_len  = term ? term_len : end_len;
  assign min_len  = codec_mode_i ? (PW+1)'(HevcMinLen) : (PW+1)'(H264MinLen);
  assign len_ok   = (rep_len > min_len);
  assign key_hit  = len_ok && (type_a == key_type_i);
  assign found    = key_seen_q | (rep & key_hit);

  // next state
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    recent_d   = recent_q;
    start_d    = start_q;
    type_d     = type_q;
    key_seen_d = key_seen_q;
    if (fire_i) begin
      if (last_i) begin
        phase_d    = PH_SEARCH;
        pos_d      = '0;
        recent_d   = RECENT_RESET;
        start_d    = '0;
        type_d     = '0;
        key_seen_d = 1'b0;
      end else begin
        pos_d      = pos_q + PW'(1);
        recent_d   = {recent_q[15:0], byte_i};
        key_seen_d = found;
        if (open_unit) begin
          phase_d = PH_HEADER;
          // a leading zero makes it a four byte start code
          start_d = (recent_q[23:16] == 8'h00) ? pos_q - PW'(3) : pos_q - PW'(2);
          type_d  = '0;
        end else begin
          phase_d = phase_a;
          type_d  = type_a;
        end
      end
    end
  end

  // results
  always_comb begin
    push_o = '0;
    push_o.rep                    = rep;
    push_o.rep_res.kind           = 1'b0;
    push_o.rep_res.offset         = OffsetBits'(start_q);
    push_o.rep_res.length         = LengthBits'(rep_len);
    push_o.rep_res.unit_type      = type_a;
    push_o.rep_res.type_valid     = len_ok;
    push_o.rep_res.is_key         = key_hit;
    push_o.rep_res.keyframe_found = found;
    push_o.rep_res.last           = 1'b0;
    push_o.sum                    = fire_i && last_i;
    push_o.sum_res.kind           = 1'b1;
    push_o.sum_res.keyframe_found = found;
    push_o.sum_res.last           = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      pos_q      <= '0;
      recent_q   <= RECENT_RESET;
      start_q    <= '0;
      type_q     <= '0;
      key_seen_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      recent_q   <= recent_d;
      start_q    <= start_d;
      type_q     <= type_d;
      key_seen_q <= key_seen_d;
    end
  end

  `include "annexb_nal_unit_scanner_defines.svh"

  `ANNEXB_ASSERT_CLK(a_clear_after_last, clk_i, rst_ni, (fire_i && last_i) |=> (phase_q == PH_SEARCH && pos_q == '0 && !key_seen_q), "scan state not cleared after last beat")
  `ANNEXB_ASSERT_CLK(a_header_follows_code, clk_i, rst_ni, (phase_q == PH_HEADER) |-> (recent_q[15:0] == 16'h0001), "header phase without a start code behind it")
  `ANNEXB_ASSERT_CLK(a_key_sets_found, clk_i, rst_ni, (push_o.rep && push_o.rep_res.is_key) |-> (push_o.rep_res.keyframe_found && push_o.rep_res.type_valid), "keyframe report without found flag")

endmodule

/* design/annexb_result_fifo.sv */
// four entry result queue between the scanner and the output channel
// depends on annexb_pkg and annexb_nal_unit_scanner_defines.svh
module annexb_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  annexb_pkg::push_t   push_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output annexb_pkg::result_t res_o
);
  import annexb_pkg::*;

  localparam int unsigned CntBits = FifoPtrBits + 1;

  result_t                 mem_q [FifoDepth];
  logic [FifoPtrBits-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]      count_q, count_d;
  logic [1:0]              n_push;
  logic                    pop;
  result_t                 first_res;

  assign n_push    = {1'b0, push_i.rep} + {1'b0, push_i.sum};
  assign first_res = push_i.rep ? push_i.rep_res : push_i.sum_res;
  assign valid_o   = (count_q != '0);
  assign pop       = valid_o && ready_i;
  assign res_o     = mem_q[rd_ptr_q];
  // keep space for a report and a summary from the same beat
  assign room_o    = (count_q <= CntBits'(FifoDepth - 2));

  assign wr_ptr_d = wr_ptr_q + FifoPtrBits'(n_push);
  assign rd_ptr_d = rd_ptr_q + FifoPtrBits'(pop);
  assign count_d  = count_q + CntBits'(n_push) - CntBits'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= first_res;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrBits'(1)] <= push_i.sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `include "annexb_nal_unit_scanner_defines.svh"

  `ANNEXB_ASSERT_ALWAYS(a_count_bound, clk_i, (count_q <= CntBits'(FifoDepth)), "result queue count out of range")
  `ANNEXB_ASSERT_CLK(a_no_overflow, clk_i, rst_ni, (n_push != 2'd0) |-> (CntBits'(n_push) <= CntBits'(FifoDepth) - count_q), "result queue overflow")
  `ANNEXB_ASSERT_CLK(a_pop_drains, clk_i, rst_ni, (pop && n_push == 2'd0) |=> (count_q == $past(count_q) - CntBits'(1)), "pop did not drain an entry")

endmodule

/* tb/tb_annexb_nal_unit_scanner.sv */
`timescale 1ns / 100ps
// testbench for the annex b start code scanner: byte stream in, unit reports out
// depends on annexb_pkg and annexb_nal_unit_scanner; a scoreboard class predicts
// every report and summary and checks each result beat as it leaves the block
module tb_annexb_nal_unit_scanner;
  import annexb_pkg::*;

  class nal_scoreboard;
    logic              mode;
    logic [5:0]        key_sel;
    logic [23:0]       pos;
    logic [23:0]       recent;
    logic [23:0]       unit_start;
    logic [5:0]        unit_type;
    logic              key_seen;
    scan_phase_e       phase;
    result_t           expected_q[$];
    int                errors;
    int                units;
    int                keys;
    int                summaries;

    function new();
      mode = 1'b0;
      key_sel = 6'd5;
      errors = 0;
      units = 0;
      keys = 0;
      summaries = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      pos = '0;
      recent = RECENT_RESET;
      unit_start = '0;
      unit_type = '0;
      key_seen = 1'b0;
      phase = PH_SEARCH;
    endfunction

    function void set_config(reg_index_e idx, logic [31:0] value);
      if (idx == REG_CODEC_MODE) begin
        mode = value[0];
      end else begin
        key_sel = value[5:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // threshold and key type are taken when the unit closes
    function void close_unit(logic [24:0] len);
      result_t r;
      int unsigned min_len;
      min_len = mode ? HevcMinLen : H264MinLen;
      r = '0;
      r.offset = unit_start;
      r.length = len;
      r.unit_type = unit_type;
      r.type_valid = len > min_len;
      r.is_key = r.type_valid && (unit_type == key_sel);
      if (r.is_key) key_seen = 1'b1;
      r.keyframe_found = key_seen;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      logic [23:0] p;
      logic        two_zeros;
      result_t     s;
      p = pos;
      two_zeros = (recent[15:0] == 16'h0000);
      if (phase == PH_HEADER) begin
        unit_type = mode ? b[6:1] : {1'b0, b[4:0]};
        phase = PH_UNIT;
      end else if (phase == PH_UNIT && two_zeros && b <= START_CODE_END) begin
        close_unit({1'b0, p - 24'd2 - unit_start});
        phase = PH_SEARCH;
      end
      // a start code on the buffer's final byte opens nothing
      if (phase == PH_SEARCH && two_zeros && b == START_CODE_END && !eob) begin
        unit_start = (recent[23:16] == 8'h00) ? p - 24'd3 : p - 24'd2;
        unit_type = '0;
        phase = PH_HEADER;
      end
      if (eob) begin
        if (phase == PH_UNIT) close_unit({1'b0, p - unit_start} + 25'd1);
        s = '0;
        s.kind = 1'b1;
        s.keyframe_found = key_seen;
        s.last = 1'b1;
        expected_q.push_back(s);
        clear_scan();
      end else begin
        recent = {recent[15:0], b};
        pos = p + 24'd1;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
      errors++;
    endtask

    task check_result(logic kind, logic [63:0] data, logic eob);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", {31'b0, kind}, 32'b0);
        return;
      end
      want = expected_q.pop_front();
      if (kind != want.kind) report_mismatch("result_kind", {31'b0, kind}, {31'b0, want.kind});
      if (data[23:0] != want.offset)
        report_mismatch("unit_offset", 32'(data[23:0]), 32'(want.offset));
      if (data[48:24] != want.length)
        report_mismatch("unit_length", 32'(data[48:24]), 32'(want.length));
      if (data[54:49] != want.unit_type)
        report_mismatch("unit_type", 32'(data[54:49]), 32'(want.unit_type));
      if (data[55] != want.type_valid)
        report_mismatch("type_valid", {31'b0, data[55]}, {31'b0, want.type_valid});
      if (data[56] != want.is_key)
        report_mismatch("is_key", {31'b0, data[56]}, {31'b0, want.is_key});
      if (data[57] != want.keyframe_found)
        report_mismatch("keyframe_found", {31'b0, data[57]}, {31'b0, want.keyframe_found});
      if (data[63:58] != 6'b0) report_mismatch("tdata padding", 32'(data[63:58]), 32'b0);
      if (eob != want.last) report_mismatch("last_result", {31'b0, eob}, {31'b0, want.last});
      if (want.kind) summaries++;
      else units++;
      if (want.is_key) keys++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nal_scoreboard sb;
  logic [7:0]    stream_q[$];
  logic          cfg_mode;
  logic [5:0]    cfg_key;
  int            bytes_sent;
  int            cfg_writes;
  logic          steady;

  annexb_nal_unit_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // no idling in a long stretch in the middle of the run
  assign steady = (bytes_sent >= 700) && (bytes_sent < 1000);

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
    end
  end

  task send_byte(input logic [7:0] b, input logic eob);
    // idle cycles drawn one at a time
    while (!steady && $urandom_range(99) < 28) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, eob);
    bytes_sent++;
  endtask

  task apb_write(input reg_index_e idx, input logic [31:0] value);
    logic [31:0] got;
    logic [31:0] want;
    want = (idx == REG_CODEC_MODE) ? {31'b0, value[0]} : {26'b0, value[5:0]};
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_config(idx, value);
    cfg_writes++;
    // read back through a second transfer
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got != want) sb.report_mismatch("register readback", got, want);
  endtask

  // registers change only once every result is out and the scanner has settled
  task reconfigure(input logic m, input logic [5:0] k);
    logic [31:0] r;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    r = $urandom();
    r[0] = m;
    apb_write(REG_CODEC_MODE, r);
    r = $urandom();
    r[5:0] = k;
    apb_write(REG_KEY_TYPE, r);
    cfg_mode = m;
    cfg_key = k;
  endtask

  task reconfigure_random();
    logic       m;
    logic [5:0] k;
    m = 1'($urandom);
    case ($urandom_range(5))
      0: k = 6'd0;
      1: k = 6'd63;
      default: k = 6'($urandom_range(m ? 63 : 31));
    endcase
    reconfigure(m, k);
  endtask

  task play_stream(input int split_at);
    for (int i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
      if (i == split_at) reconfigure_random();
    end
  endtask

  function logic [7:0] gen_header();
    logic [5:0] t;
    t = ($urandom_range(2) == 0) ? cfg_key : 6'($urandom);
    if (cfg_mode) return {1'($urandom), t, 1'($urandom)};
    return {3'($urandom), t[4:0]};
  endfunction

  function logic [7:0] gen_payload();
    if ($urandom_range(9) == 0) return 8'h00;
    return 8'($urandom);
  endfunction

  // mostly well formed units with random content; some buffers are pure noise
  task build_buffer();
    int units;
    int plen;
    stream_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) begin
        case ($urandom_range(3))
          0: stream_q.push_back(8'h00);
          1: stream_q.push_back(8'h01);
          default: stream_q.push_back(8'($urandom));
        endcase
      end
      return;
    end
    units = $urandom_range(1, 4);
    repeat (units) begin
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom_range(2, 255)));
      end
      if ($urandom_range(1)) stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h01);
      stream_q.push_back(gen_header());
      plen = $urandom_range(0, 10);
      repeat (plen) stream_q.push_back(gen_payload());
    end
    case ($urandom_range(7))
      0: begin
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h01);
      end
      1: begin
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h01);
        stream_q.push_back(gen_header());
      end
      2: begin
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
      end
      3: begin
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
      end
      default: ;
    endcase
  endtask

  initial begin
    int nbuf;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_mode = 1'b0;
    cfg_key = 6'd5;
    bytes_sent = 0;
    cfg_writes = 0;
    nbuf = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // four-byte start code, start code ending a unit, 000000 on the last byte
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hAA, 8'hBB, 8'h00, 8'h00, 8'h01,
                 8'h05, 8'hFF, 8'h00, 8'h00, 8'h00};
    play_stream(-1);
    // start code on the last byte opens nothing
    stream_q = '{8'h00, 8'h00, 8'h01};
    play_stream(-1);
    // header on the last byte: short unit whose type does not count
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h25};
    play_stream(-1);
    stream_q = '{8'hFF};
    play_stream(-1);

    reconfigure(1'b1, 6'd63);
    reconfigure(1'b0, 6'd0);
    while (bytes_sent < 1750) begin
      if (nbuf % 6 == 5) reconfigure_random();
      build_buffer();
      play_stream(($urandom_range(6) == 0) ? $urandom_range(0, stream_q.size() - 1) : -1);
      nbuf++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("fed %0d bytes in %0d buffers with %0d register writes", bytes_sent, nbuf + 4,
             cfg_writes);
    $display("checked %0d unit reports (%0d keyframe units) and %0d buffer summaries",
             sb.units, sb.keys, sb.summaries);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
